>>> design/ucf_pkg.sv
// ----------------------------------------------------------------------------
// ucf_pkg
// Shared types, constants and arithmetic helpers for the universal comb filter.
// ----------------------------------------------------------------------------
package ucf_pkg;

  // field widths
  localparam int unsigned DataW  = 24;
  localparam int unsigned GainW  = 18;
  localparam int unsigned DelayW = 12;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ProdW  = DataW + GainW;      // full product
  localparam int unsigned RndW   = ProdW - 16;         // product after q16 rounding
  localparam int unsigned SumW   = RndW + 1;           // sum of two rounded terms

  // default ring depth
  localparam int unsigned RingDepthDef = 4096;

  // q2.16 one and gain reset values
  localparam logic signed [GainW-1:0] OneQ16     = 18'sd65536;
  localparam logic signed [GainW-1:0] MinusOneQ16 = -18'sd65536;

  // saturation limits
  localparam logic signed [SumW-1:0] S24Max = SumW'(8388607);
  localparam logic signed [SumW-1:0] S24Min = -SumW'(8388608);

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DELAY    = 2'd0,
    CFG_BLEND    = 2'd1,
    CFG_FEEDBACK = 2'd2,
    CFG_FEEDFWD  = 2'd3
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FB,
    S_FF,
    S_BL,
    S_OUT
  } state_e;

  // operand pair for the shared multiplier
  typedef enum logic [1:0] {
    SEL_FB,
    SEL_FF,
    SEL_BL
  } mul_sel_e;

  // control from the sequencer to the datapath
  typedef struct packed {
    logic     accept;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     v_load;
    logic     acc_load;
    logic     ring_wr;
    logic     out_load;
  } ctrl_t;

  // round a q16 product to nearest, ties upward
  function automatic logic signed [RndW-1:0] round_q16(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] b;
    b = p + ProdW'(32768);
    return b[ProdW-1:16];
  endfunction

  // saturate a sum to signed 24 bits
  function automatic logic signed [DataW-1:0] sat24(input logic signed [SumW-1:0] s);
    logic signed [DataW-1:0] r;
    if (s > S24Max) begin
      r = S24Max[DataW-1:0];
    end else if (s < S24Min) begin
      r = S24Min[DataW-1:0];
    end else begin
      r = s[DataW-1:0];
    end
    return r;
  endfunction

  // limit feedback to minus one .. one
  function automatic logic signed [GainW-1:0] clamp_fb(input logic signed [GainW-1:0] g);
    logic signed [GainW-1:0] r;
    if (g > OneQ16) begin
      r = OneQ16;
    end else if (g < MinusOneQ16) begin
      r = MinusOneQ16;
    end else begin
      r = g;
    end
    return r;
  endfunction

endpackage

>>> design/universal_comb_filter_unit.sv
// ----------------------------------------------------------------------------
// universal_comb_filter_unit
// Universal comb filter for signed 24-bit audio with q2.16 gains.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_ready_o carries one sample_in_i per beat,
//   output channel out_valid_o / out_ready_i carries one sample_out_o per beat.
//   Every input beat gives exactly one output beat, in order.
//   Gains and delay are written through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   while the block is idle; writes take effect at once.
// Sequence:
//   A sample takes one ring read and three passes through the one shared
//   multiplier (feedback, feedforward, blend) in states S_FB, S_FF, S_BL.
//   The result enters the output register in S_OUT, which sets out_valid_o.
//   A new sample is taken only while idle, or in S_OUT as the previous
//   result enters the output register once that register is free.
// Reset:
//   Delay 1, blend 0, feedback 0, feedforward 1.0. The history ring is not
//   swept; a fill flag and the write pointer make unwritten entries read as
//   zero, so the block takes samples straight out of reset.
// Stall:
//   A result waits in the output register while out_ready_i is low; the next
//   sample is still processed and waits in the sequencer until the register
//   frees.
// ----------------------------------------------------------------------------
module universal_comb_filter_unit #(
  parameter int unsigned RING_DEPTH = ucf_pkg::RingDepthDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ucf_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [ucf_pkg::GainW-1:0]            cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [ucf_pkg::DataW-1:0]     sample_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [ucf_pkg::DataW-1:0]     sample_out_o
);
  import ucf_pkg::*;

  localparam int unsigned PtrW = $clog2(RING_DEPTH);
  localparam int unsigned CmpW = ((PtrW > DelayW) ? PtrW : DelayW) + 1;

  ctrl_t ctrl;

  logic [PtrW-1:0]          delay_q;
  logic signed [GainW-1:0]  blend_q, fb_q, ff_q;
  logic [CmpW-1:0]          dl_ext, dl_eff;

  logic signed [DataW-1:0]  x_q, v_q, v_d, d;
  logic signed [RndW-1:0]   acc_q, rnd;
  logic signed [DataW-1:0]  mul_a, y;
  logic signed [GainW-1:0]  mul_g;
  logic signed [DataW-1:0]  out_q;
  logic                     out_valid_q, out_valid_d;
  logic                     out_free;

  // delay limited to one .. depth minus one
  always_comb begin
    dl_ext = CmpW'(cfg_wdata_i[DelayW-1:0]);
    if (dl_ext == '0) begin
      dl_eff = CmpW'(1);
    end else if (dl_ext >= CmpW'(RING_DEPTH)) begin
      dl_eff = CmpW'(RING_DEPTH - 1);
    end else begin
      dl_eff = dl_ext;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= PtrW'(1);
      blend_q <= '0;
      fb_q    <= '0;
      ff_q    <= OneQ16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DELAY:    delay_q <= dl_eff[PtrW-1:0];
        CFG_BLEND:    blend_q <= cfg_wdata_i;
        CFG_FEEDBACK: fb_q    <= clamp_fb(cfg_wdata_i);
        CFG_FEEDFWD:  ff_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer
  assign out_free = !out_valid_q || out_ready_i;

  ucf_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  // history ring
  ucf_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .delay_i   (delay_q),
    .rd_en_i   (ctrl.accept),
    .wr_en_i   (ctrl.ring_wr),
    .wr_data_i (v_q),
    .rd_data_o (d)
  );

  // operand selection for the shared multiplier
  always_comb begin
    unique case (ctrl.mul_sel)
      SEL_FB: begin
        mul_a = d;
        mul_g = fb_q;
      end
      SEL_FF: begin
        mul_a = d;
        mul_g = ff_q;
      end
      SEL_BL: begin
        mul_a = v_q;
        mul_g = blend_q;
      end
      default: begin
        mul_a = d;
        mul_g = fb_q;
      end
    endcase
  end

  ucf_mul u_mul (
    .clk_i (clk_i),
    .en_i  (ctrl.mul_en),
    .a_i   (mul_a),
    .g_i   (mul_g),
    .rnd_o (rnd)
  );

  // internal value and output sum
  assign v_d = sat24(SumW'(x_q) + SumW'(rnd));
  assign y   = sat24(SumW'(acc_q) + SumW'(rnd));

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      x_q <= sample_in_i;
    end
    if (ctrl.v_load) begin
      v_q <= v_d;
    end
    if (ctrl.acc_load) begin
      acc_q <= rnd;
    end
    if (ctrl.out_load) begin
      out_q <= y;
    end
  end

  // output beat holding register
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

endmodule

>>> design/ucf_ring.sv
// ----------------------------------------------------------------------------
// ucf_ring
// History ring of past internal values with write pointer and fill tracking.
// ----------------------------------------------------------------------------
module ucf_ring #(
  parameter int unsigned RING_DEPTH = ucf_pkg::RingDepthDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [$clog2(RING_DEPTH)-1:0]         delay_i,
  input  logic                                  rd_en_i,
  input  logic                                  wr_en_i,
  input  logic signed [ucf_pkg::DataW-1:0]      wr_data_i,
  output logic signed [ucf_pkg::DataW-1:0]      rd_data_o
);
  import ucf_pkg::*;

  localparam int unsigned PtrW = $clog2(RING_DEPTH);

  logic signed [DataW-1:0] mem [RING_DEPTH];
  logic [PtrW-1:0]         wp_q, wp_d;
  logic                    filled_q, filled_d;
  logic                    hit_q, hit_d;
  logic signed [DataW-1:0] rd_data_q;
  logic [PtrW-1:0]         rd_addr;
  logic [PtrW:0]           wrap_addr;
  logic                    no_wrap;

  // delayed read address, modulo ring depth
  always_comb begin
    no_wrap   = (wp_q >= delay_i);
    wrap_addr = {1'b0, wp_q} + (PtrW + 1)'(RING_DEPTH) - {1'b0, delay_i};
    if (no_wrap) begin
      rd_addr = wp_q - delay_i;
    end else begin
      rd_addr = wrap_addr[PtrW-1:0];
    end
    // entries below the pointer are written until the first wrap
    hit_d = filled_q || no_wrap;
  end

  // write pointer and fill flag
  always_comb begin
    wp_d     = wp_q;
    filled_d = filled_q;
    if (wr_en_i) begin
      if (wp_q == PtrW'(RING_DEPTH - 1)) begin
        wp_d     = '0;
        filled_d = 1'b1;
      end else begin
        wp_d = wp_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      filled_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      wp_q     <= wp_d;
      filled_q <= filled_d;
      if (rd_en_i) begin
        hit_q <= hit_d;
      end
    end
  end

  // ring storage, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wp_q] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // unwritten entries read as zero
  assign rd_data_o = hit_q ? rd_data_q : '0;

endmodule

>>> design/ucf_mul.sv
// ----------------------------------------------------------------------------
// ucf_mul
// Shared sample by gain multiplier with registered product and q16 rounding.
// ----------------------------------------------------------------------------
module ucf_mul (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [ucf_pkg::DataW-1:0]  a_i,
  input  logic signed [ucf_pkg::GainW-1:0]  g_i,
  output logic signed [ucf_pkg::RndW-1:0]   rnd_o
);
  import ucf_pkg::*;

  logic signed [ProdW-1:0] prod_q, prod_d;

  // full-width product
  assign prod_d = ProdW'(a_i) * ProdW'(g_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // round to nearest on the registered product
  assign rnd_o = round_q16(prod_q);

endmodule

>>> design/ucf_seq.sv
// ----------------------------------------------------------------------------
// ucf_seq
// Sequencer stepping one sample through the shared multiplier.
// ----------------------------------------------------------------------------
module ucf_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_free_i,
  output logic           in_ready_o,
  output ucf_pkg::ctrl_t ctrl_o
);
  import ucf_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  // new beat taken when idle, or when the result leaves this cycle
  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_OUT) && out_free_i);
  assign accept     = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_FB;
      end
      S_FB: state_d = S_FF;
      S_FF: state_d = S_BL;
      S_BL: state_d = S_OUT;
      S_OUT: begin
        if (out_free_i) begin
          state_d = accept ? S_FB : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctrl_o          = '0;
    ctrl_o.accept   = accept;
    ctrl_o.mul_sel  = SEL_FB;
    unique case (state_q)
      S_IDLE: ;
      S_FB: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = SEL_FB;
      end
      S_FF: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = SEL_FF;
        ctrl_o.v_load  = 1'b1;
      end
      S_BL: begin
        ctrl_o.mul_en   = 1'b1;
        ctrl_o.mul_sel  = SEL_BL;
        ctrl_o.acc_load = 1'b1;
        ctrl_o.ring_wr  = 1'b1;
      end
      S_OUT: begin
        ctrl_o.out_load = out_free_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/ucf_checker.sv
// ----------------------------------------------------------------------------
// ucf_checker
// Port-level checks on sequencing and output beat handling of the comb filter.
// ----------------------------------------------------------------------------
module ucf_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_we_i,
  input logic [ucf_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input logic [ucf_pkg::GainW-1:0]         cfg_wdata_i,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic signed [ucf_pkg::DataW-1:0]  sample_in_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [ucf_pkg::DataW-1:0]  sample_out_o
);
  import ucf_pkg::*;

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_o;

  // input ready stays low while a sample passes through the multiplier after its beat
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |-> ##1 !in_ready_o ##1 !in_ready_o ##1 !in_ready_o)
    else $error("input ready during multiplier passes");

  // a fresh result follows the final multiplier pass
  a_result_after_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o, 2))
    else $error("result appeared without a completed pass");

  // a stalled output beat keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_out_o))
    else $error("stalled output beat changed");

  // a register write while a sample is offered carries known index, data and sample
  a_no_cfg_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !$isunknown(cfg_idx_i) && !$isunknown(cfg_wdata_i)
                 && !$isunknown(sample_in_i) || !in_valid_i)
    else $error("unknown configuration write");

endmodule

bind universal_comb_filter_unit ucf_checker u_ucf_checker (.*);

>>> test/tb_universal_comb_filter_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_universal_comb_filter_unit
// Self-checking bench for the universal comb filter. A bit-exact software
// copy of the filter, with its own history ring, predicts each output sample
// and every output beat is checked in order against it. A directed part covers
// the sample extremes, rounding ties, the gain extremes and the delay limits;
// then phases of random samples under random settings follow. Idle gaps on
// the input and stalls on the output come at random.
// ----------------------------------------------------------------------------
module tb_universal_comb_filter_unit;
  import ucf_pkg::*;

  localparam int unsigned Depth        = RingDepthDef;
  localparam int unsigned PtrW         = $clog2(Depth);
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned NumPhases    = 10;
  localparam int unsigned PhaseSamples = 103;

  typedef enum int {
    RX_FREE,
    RX_COIN,
    RX_SPARSE,
    RX_BURSTY
  } rx_mode_e;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    cfg_we    = 1'b0;
  cfg_idx_e                cfg_idx   = CFG_DELAY;
  logic [GainW-1:0]        cfg_wdata = '0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic signed [DataW-1:0] sample_in = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [DataW-1:0] sample_out;

  // settings as the block should hold them
  logic [DelayW-1:0]       delay_sh;
  logic signed [GainW-1:0] blend_sh;
  logic signed [GainW-1:0] fb_sh;
  logic signed [GainW-1:0] ff_sh;

  // software history ring of internal values
  logic signed [DataW-1:0] history [Depth];
  int unsigned             wr_ptr;

  logic signed [DataW-1:0] expected_out_q [$];
  logic signed [DataW-1:0] want;
  int                      n_fail      = 0;
  int                      idle_cycles = 0;
  int                      burst_left  = 0;
  rx_mode_e                rx_mode     = RX_FREE;
  int                      rx_mode_left = 0;
  int                      rx_hold     = 0;

  universal_comb_filter_unit u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .sample_in_i  (sample_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .sample_out_o (sample_out)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // sample times gain, rounded to nearest with ties upward
  function automatic longint scaled_sample(input logic signed [DataW-1:0] a,
                                           input logic signed [GainW-1:0] g);
    longint p;
    p = longint'(a) * longint'(g);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [DataW-1:0] clip_s24(input longint s);
    if (s > 64'sd8388607) return 24'sh7FFFFF;
    if (s < -64'sd8388608) return 24'sh800000;
    return s[DataW-1:0];
  endfunction

  // one filter step: read delayed value, form v and y, store v
  function automatic logic signed [DataW-1:0] comb_filter_step(
      input logic signed [DataW-1:0] x);
    int unsigned             lag;
    int unsigned             rd;
    logic signed [GainW-1:0] fb;
    logic signed [DataW-1:0] d;
    logic signed [DataW-1:0] v;
    logic signed [DataW-1:0] y;
    lag = 32'(delay_sh);
    if (lag == 0) lag = 1;
    if (lag >= Depth) lag = Depth - 1;
    fb = fb_sh;
    if (fb > OneQ16) fb = OneQ16;
    if (fb < MinusOneQ16) fb = MinusOneQ16;
    rd = (wr_ptr + Depth - lag) % Depth;
    d = history[rd[PtrW-1:0]];
    v = clip_s24(longint'(x) + scaled_sample(d, fb));
    y = clip_s24(scaled_sample(v, blend_sh) + scaled_sample(d, ff_sh));
    history[wr_ptr[PtrW-1:0]] = v;
    wr_ptr = (wr_ptr + 1) % Depth;
    return y;
  endfunction

  function automatic logic [GainW-1:0] pick_gain();
    logic [GainW-1:0] g;
    case ($urandom_range(0, 5))
      0: g = OneQ16;
      1: g = MinusOneQ16;
      2: g = 18'h1FFFF;
      3: g = 18'h20000;
      default: g = GainW'($urandom);
    endcase
    return g;
  endfunction

  function automatic logic signed [DataW-1:0] random_sample();
    logic signed [DataW-1:0] s;
    case ($urandom_range(0, 7))
      0: s = 24'sh7FFFFF;
      1: s = 24'sh800000;
      2, 3: s = DataW'($urandom_range(0, 2000) - 1000);
      default: s = DataW'($urandom);
    endcase
    return s;
  endfunction

  // register write, only while the block is idle
  task automatic write_reg(input cfg_idx_e idx, input logic [GainW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_DELAY:    delay_sh = val[DelayW-1:0];
      CFG_BLEND:    blend_sh = val;
      CFG_FEEDBACK: fb_sh = val;
      CFG_FEEDFWD:  ff_sh = val;
      default:      ;
    endcase
  endtask

  // one input beat, with random gaps between bursts
  task automatic send_sample(input logic signed [DataW-1:0] x);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    sample_in <= x;
    do @(posedge clk); while (!in_ready);
    expected_out_q.push_back(comb_filter_step(x));
  endtask

  // hold off input until every output has come back
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_out_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    burst_left = 0;
  endtask

  // reset settings: delay 1 and unity feedforward, so output is the previous input
  task automatic test_reset_defaults();
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample(24'sh000000);
    send_sample(-24'sd1);
    send_sample(24'sd1);
    send_sample(24'sh555555);
    send_sample(24'shAAAAAA);
  endtask

  // zero delay behaves as one; half gains hit rounding ties
  task automatic test_zero_delay_and_ties();
    drain_pipeline();
    write_reg(CFG_DELAY, 18'h3F000);
    write_reg(CFG_BLEND, 18'd32768);
    write_reg(CFG_FEEDFWD, 18'd32768);
    send_sample(24'sd1);
    send_sample(-24'sd1);
    send_sample(24'sd3);
  endtask

  // gain extremes; feedback beyond one is limited to one and minus one
  task automatic test_gain_extremes();
    drain_pipeline();
    write_reg(CFG_DELAY, 18'd2);
    write_reg(CFG_BLEND, 18'h1FFFF);
    write_reg(CFG_FEEDFWD, 18'h20000);
    write_reg(CFG_FEEDBACK, 18'h1FFFF);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample(24'sh800000);
    send_sample(24'sh7FFFFF);
    drain_pipeline();
    write_reg(CFG_FEEDBACK, 18'h20000);
    send_sample(24'sh800000);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
  endtask

  // longest delay, written with the unused upper bits set; feedback exactly -1
  task automatic test_longest_delay();
    drain_pipeline();
    write_reg(CFG_DELAY, 18'h3FFFF);
    write_reg(CFG_FEEDBACK, MinusOneQ16);
    write_reg(CFG_BLEND, OneQ16);
    send_sample(24'sh400000);
    send_sample(-24'sd7);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
  endtask

  // random samples under random settings, drained between phases
  task automatic test_random_phases();
    logic [GainW-1:0] dl;
    logic [GainW-1:0] fb;
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_pipeline();
      case ($urandom_range(0, 9))
        0: dl = '0;
        1: dl = 18'h00FFF;
        2: dl = GainW'($urandom);
        3, 4: dl = GainW'($urandom_range(17, 600));
        default: dl = GainW'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 4))
        0: fb = GainW'($urandom);
        1: fb = pick_gain();
        default: fb = GainW'($urandom_range(0, 120000) - 60000);
      endcase
      write_reg(CFG_DELAY, dl);
      write_reg(CFG_BLEND, pick_gain());
      write_reg(CFG_FEEDBACK, fb);
      write_reg(CFG_FEEDFWD, pick_gain());
      repeat (PhaseSamples) send_sample(random_sample());
    end
  endtask

  // output stalls, in modes that change now and then
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(50, 400);
    end
    rx_mode_left--;
    if (rx_hold != 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            rx_hold = $urandom_range(5, 30);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // compare each output beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_out_q.size() == 0) begin
        $display("%0t: unexpected output beat, expected none, got %0d",
                 $time, sample_out);
        n_fail++;
      end else begin
        want = expected_out_q.pop_front();
        if (sample_out !== want) begin
          $display("%0t: sample_out mismatch, expected %0d, got %0d",
                   $time, want, sample_out);
          n_fail++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("%0t: timeout, %0d outputs still expected", $time,
               expected_out_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // main sequence
  initial begin
    foreach (history[i]) history[i] = '0;
    wr_ptr   = 0;
    delay_sh = DelayW'(1);
    blend_sh = '0;
    fb_sh    = '0;
    ff_sh    = OneQ16;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_zero_delay_and_ties();
    test_gain_extremes();
    test_longest_delay();
    test_random_phases();
    drain_pipeline();

    if (n_fail == 0 && expected_out_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
